FILE: src/sws_pkg.sv
// Shared types and constants of the sliding window sum and statistics block.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

  // Field widths of one input word and one result word.
  localparam int SAMPLE_W    = 32;
  localparam int ENTRY_W     = 33;
  localparam int SUM_OUT_W   = 39;
  localparam int OUT_TDATA_W = 176;

  // Configuration port.
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  // Register index as seen in the address (paddr[2] selects the word).
  localparam logic REG_DELTA_MODE = 1'b0;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } sws_state_t;

endpackage : sws_pkg

`default_nettype wire

FILE: src/sws_cell.sv
// One window cell: holds one entry and takes its left neighbor's entry when the
// chain moves. Depends on sws_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none

module sws_cell
  import sws_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               move,
  input  wire logic [ENTRY_W-1:0] d_in,
  output logic      [ENTRY_W-1:0] q_out
);

  logic [ENTRY_W-1:0] entry_r;

  // The window starts cleared; those zeros take part in the statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (move) begin
      entry_r <= d_in;
    end
  end

  assign q_out = entry_r;

endmodule : sws_cell

`default_nettype wire

FILE: src/sws_div.sv
// Floor division of the running sum by the window depth. A power-of-two depth
// is an arithmetic shift; any other depth multiplies by a rounded-up reciprocal
// as a sum of 24-bit limb partial products. Depends on sws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sws_div
  import sws_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64,
  parameter int SUM_W        = 39
)
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  output logic                         done,
  output logic        [ENTRY_W-1:0]    quotient
);

  localparam bit IS_POW2 = ((WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0);
  localparam int LOG2_D  = $clog2(WINDOW_DEPTH);

  logic               done_r;
  logic [ENTRY_W-1:0] quot_r;

  assign done     = done_r;
  assign quotient = quot_r;

  if (IS_POW2) begin : g_shift
    // Arithmetic shift floors toward minus infinity.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        quot_r <= ENTRY_W'(dividend >>> LOG2_D);
      end
    end
  end else begin : g_recip
    // For any SUM_W-bit magnitude a, floor(a / depth) is (a * RECIP) >> SH.
    localparam int LW        = 24;
    localparam int SH        = SUM_W + LOG2_D;
    localparam int NA        = (SUM_W + LW - 1) / LW;
    localparam int NM        = (SUM_W + LW) / LW;
    localparam int MAG_PAD_W = NA * LW;
    localparam int RCP_PAD_W = NM * LW;
    localparam int PROD_W    = MAG_PAD_W + RCP_PAD_W;
    localparam int IDX_MAX   = (NA > NM) ? NA : NM;
    localparam int IDX_W     = (IDX_MAX > 2) ? $clog2(IDX_MAX) : 1;
    localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [RCP_PAD_W-1:0] RCP_PAD = RCP_PAD_W'(RECIP);

    logic                 busy_r;
    logic                 neg_r;
    logic [MAG_PAD_W-1:0] mag_r;
    logic [PROD_W-1:0]    acc_r;
    logic [IDX_W-1:0]     ia_r;
    logic [IDX_W-1:0]     im_r;
    logic [SUM_W-1:0]     dividend_mag;
    logic [LW-1:0]        a_limb;
    logic [LW-1:0]        m_limb;
    logic [2*LW-1:0]      partial;
    logic [PROD_W-1:0]    partial_ext;
    logic                 last_step;
    logic [ENTRY_W-1:0]   q_bits;

    // A negative sum is biased by depth - 1 so that the magnitude quotient
    // rounds up, which floors the signed result.
    always_comb begin
      if (dividend[SUM_W-1]) begin
        dividend_mag = SUM_W'(-dividend) + SUM_W'(WINDOW_DEPTH - 1);
      end else begin
        dividend_mag = SUM_W'(dividend);
      end
      a_limb      = mag_r[ia_r * LW +: LW];
      m_limb      = RCP_PAD[im_r * LW +: LW];
      partial     = a_limb * m_limb;
      partial_ext = PROD_W'(partial) << (LW * (ia_r + im_r));
      last_step   = (ia_r == IDX_W'(NA - 1)) && (im_r == IDX_W'(NM - 1));
      q_bits      = acc_r[SH +: ENTRY_W];
      quot_r      = neg_r ? (~q_bits + 1'b1) : q_bits;
    end

    // One partial product per cycle, magnitude limbs inner, reciprocal limbs outer.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        done_r <= 1'b0;
        ia_r   <= '0;
        im_r   <= '0;
      end else begin
        done_r <= busy_r && !start && last_step;
        if (start) begin
          busy_r <= 1'b1;
          ia_r   <= '0;
          im_r   <= '0;
        end else if (busy_r) begin
          if (last_step) begin
            busy_r <= 1'b0;
          end else if (ia_r == IDX_W'(NA - 1)) begin
            ia_r <= '0;
            im_r <= im_r + 1'b1;
          end else begin
            ia_r <= ia_r + 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        neg_r <= dividend[SUM_W-1];
        mag_r <= MAG_PAD_W'(dividend_mag);
        acc_r <= '0;
      end else if (busy_r) begin
        acc_r <= acc_r + partial_ext;
      end
    end
  end

endmodule : sws_div

`default_nettype wire

FILE: src/sliding_window_sum_stats.sv
// Top level of the sliding window sum and statistics block: sequencer, window
// cell chain, running sum, max/min tracking and result register.
// Depends on sws_pkg, sws_cell and sws_div.
//
//  Channel   Direction  Handshake                     Payload
//  in_       sink       in_tvalid / in_tready         in_tdata: sample
//  out_      source     out_tvalid / out_tready       out_tdata: five result fields
//  cfg_      APB slave  psel, penable, pwrite, pready delta_mode at byte address 0
//
// A word is taken only in the idle state. Its result is loaded after the shift,
// a full rotation of the chain past the max/min comparator and the divide:
// a shift for a power-of-two depth, the multiply steps of sws_div for other
// depths. The next word is taken only once that result is loaded.
// Reset is synchronous and clears the window, sum, previous sample and mode.
// A result waiting on out_tready does not block acceptance of the next word;
// only the final load of the result register waits for it.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_sum_stats
  import sws_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
)
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [SAMPLE_W-1:0]    in_tdata,    // [31:0] sample
  // Result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [32:0] newest_entry, [71:33] window_sum, [104:72] window_average,
  // [137:105] window_maximum, [170:138] window_minimum, [175:171] zero
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // Configuration port
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int SUM_W = ENTRY_W + $clog2(WINDOW_DEPTH);
  localparam int EXT_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int CNT_W = (WINDOW_DEPTH > 2) ? $clog2(WINDOW_DEPTH) : 1;

  sws_state_t state_r, state_nxt;

  logic                      delta_mode_r;
  logic [SAMPLE_W-1:0]       sample_r;
  logic [SAMPLE_W-1:0]       prev_r;
  logic signed [ENTRY_W-1:0] entry_r;
  logic signed [ENTRY_W-1:0] entry_c;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [EXT_W-1:0]   sum_ext;
  logic signed [ENTRY_W-1:0] max_r, min_r;
  logic [CNT_W-1:0]          scan_cnt_r;
  logic                      scan_last;

  logic                      chain_move;
  logic [ENTRY_W-1:0]        chain_in;
  logic signed [ENTRY_W-1:0] cell_q [WINDOW_DEPTH];
  logic signed [ENTRY_W-1:0] head;

  logic                      div_start;
  logic                      div_done;
  logic [ENTRY_W-1:0]        div_quot;
  logic                      out_load;

  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;

  // Configuration register write and read-back.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_DELTA_MODE) ?
                      CFG_DATA_W'(delta_mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_DELTA_MODE)) begin
      delta_mode_r <= cfg_pwdata[0];
    end
  end

  // New entry: the sample itself, or its difference from the previous one.
  assign entry_c = delta_mode_r ? ({1'b0, sample_r} - {1'b0, prev_r}) : {1'b0, sample_r};

  assign head      = cell_q[WINDOW_DEPTH-1];
  assign scan_last = (scan_cnt_r == CNT_W'(WINDOW_DEPTH - 1));

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_last) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_tready  = 1'b0;
    chain_move = 1'b0;
    chain_in   = head;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_SHIFT: begin
        chain_move = 1'b1;
        chain_in   = entry_c;
      end
      ST_SCAN: begin
        chain_move = 1'b1;
        div_start  = scan_last;
      end
      ST_DIV:   ;
      ST_DONE:  out_load = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Window chain: shifts the new entry in, then rotates once for the scan.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    sws_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .move  (chain_move),
      .d_in  ((i == 0) ? chain_in : cell_q[(i == 0) ? 0 : i - 1]),
      .q_out (cell_q[i])
    );
  end

  // Sample capture and previous sample for delta mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (state_r == ST_SHIFT && delta_mode_r) begin
      prev_r <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sample_r <= in_tdata;
    end
  end

  // Running sum: the leaving entry comes off at the shift, the new one goes on
  // in the first scan cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (state_r == ST_SHIFT) begin
      sum_r <= sum_r - SUM_W'(head);
    end else if (state_r == ST_SCAN && scan_cnt_r == '0) begin
      sum_r <= sum_r + SUM_W'(entry_r);
    end
  end

  // Max/min tracking over the head cell while the chain rotates.
  always_ff @(posedge clk) begin
    if (state_r == ST_SHIFT) begin
      entry_r <= entry_c;
      max_r   <= entry_c;
      min_r   <= entry_c;
    end else if (state_r == ST_SCAN) begin
      if (head > max_r) max_r <= head;
      if (head < min_r) min_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
    end else if (state_r == ST_SHIFT) begin
      scan_cnt_r <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
  end

  // Floor average of the finished sum.
  sws_div #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign sum_ext = EXT_W'(sum_r);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {5'b0, min_r, max_r, div_quot, sum_ext[SUM_OUT_W-1:0], entry_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // An accepted word reaches the scan right after the shift state.
  a_accept_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> ##2 (state_r == ST_SCAN))
    else $error("accepted word did not reach the scan");

  // The divider only reports while the sequencer waits on it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // A full rotation brings the newest entry back to the first cell.
  a_rotation_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cell_q[0] == entry_r))
    else $error("window rotation did not close");

  // The scanned maximum never falls below the minimum.
  a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (max_r >= min_r))
    else $error("window maximum below minimum");

endmodule : sliding_window_sum_stats

`default_nettype wire
